>>> rtl/uart_baud_divisor_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// assertion macros for the baud divisor encoder core
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef UART_BAUD_DIVISOR_ENCODER_CORE_ASSERT_SVH
`define UART_BAUD_DIVISOR_ENCODER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define UBDE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UBDE_ASSERT_NEVER(label, cond, msg) \
    `UBDE_ASSERT(label, !(cond), msg)
`else
`define UBDE_ASSERT(label, prop, msg)
`define UBDE_ASSERT_NEVER(label, cond, msg)
`endif
`endif

>>> rtl/ubde_pkg.sv
// ----------------------------------------------------------------------------
// ubde_pkg
// types, constants and stage functions of the baud divisor encoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ubde_pkg;

    localparam int BASE_W         = 28;   // clock and quotient width
    localparam int BAUD_W         = 32;
    localparam int DVS_W          = 23;   // widest divisor: slow-path baud
    localparam int DIV8_W         = 18;
    localparam int ENC_W          = 17;
    localparam int ACH_W          = 24;
    localparam int VAL_W          = 16;
    localparam int CMP_W          = 38;
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = BASE_W / BITS_PER_STAGE;
    localparam int NUM_STAGES     = 2 * DIV_STAGES + 2;
    localparam int MID_IDX        = DIV_STAGES + 1;
    localparam int LAST_IDX       = NUM_STAGES - 1;
    localparam int M_TDATA_W      = ((ACH_W + VAL_W + 1 + 7) / 8) * 8;
    localparam int PAD_W          = M_TDATA_W - ACH_W - VAL_W - 1;

    localparam logic [BASE_W-1:0] CLOCK_RESET     = BASE_W'(48000000);
    localparam logic [BASE_W-1:0] DIV_CLAMP_LIMIT = BASE_W'(32'h20000);
    localparam logic [BASE_W-1:0] DIV_CLAMP_VALUE = BASE_W'(32'h1ffff);

    localparam logic [ENC_W-1:0] ENC_FAST16 = ENC_W'(0);
    localparam logic [ENC_W-1:0] ENC_FAST24 = ENC_W'(1);
    localparam logic [ENC_W-1:0] ENC_FAST32 = ENC_W'(2);

    localparam logic [DVS_W-1:0] DVS_FAST16 = DVS_W'(16);
    localparam logic [DVS_W-1:0] DVS_FAST24 = DVS_W'(24);
    localparam logic [DVS_W-1:0] DVS_FAST32 = DVS_W'(32);
    localparam logic [DVS_W-1:0] DVS_UNIT   = DVS_W'(1);

    typedef enum logic [1:0] {
        KIND_SLOW,
        KIND_FAST16,
        KIND_FAST24,
        KIND_FAST32
    } kind_t;

    typedef struct packed {
        logic              rej;
        kind_t             kind;
        logic [BASE_W-1:0] base;
        logic [DVS_W-1:0]  dvs;
        logic [DVS_W-1:0]  rem;
        logic [BASE_W-1:0] dq;    // dividend bits shift out, quotient bits shift in
        logic [ENC_W-1:0]  enc;
    } pl_t;

    typedef struct packed {
        logic             rejected;
        logic [ACH_W-1:0] achieved;
        logic [VAL_W-1:0] value;
        logic             index;
    } out_t;

    function automatic logic [2:0] frac_remap(input logic [2:0] sel);
        logic [2:0] r;
        unique case (sel)
            3'd0: r = 3'd0;
            3'd1: r = 3'd3;
            3'd2: r = 3'd2;
            3'd3: r = 3'd4;
            3'd4: r = 3'd1;
            3'd5: r = 3'd5;
            3'd6: r = 3'd6;
            3'd7: r = 3'd7;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    // restoring division, a couple of quotient bits per stage
    function automatic pl_t div_step(input pl_t s);
        pl_t            r;
        logic [DVS_W:0] t;
        logic           qbit;
        r = s;
        for (int k = 0; k < BITS_PER_STAGE; k++)
        begin
            t    = {r.rem, r.dq[BASE_W-1]};
            qbit = (t >= {1'b0, r.dvs});
            if (qbit)
            begin
                t = t - {1'b0, r.dvs};
            end
            r.rem = t[DVS_W-1:0];
            r.dq  = {r.dq[BASE_W-2:0], qbit};
        end
        return r;
    endfunction

    // eighths divisor from the sixteenths quotient, clamp, encode, arm second divider
    function automatic pl_t mid_stage(input pl_t s);
        pl_t               r;
        logic [BASE_W-1:0] div8;
        logic [DIV8_W-1:0] d8;
        logic [ENC_W-1:0]  enc_slow;
        r    = s;
        div8 = {1'b0, s.dq[BASE_W-1:1]} + BASE_W'(s.dq[0]);
        if (div8 > DIV_CLAMP_LIMIT)
        begin
            div8 = DIV_CLAMP_VALUE;
        end
        d8       = div8[DIV8_W-1:0];
        enc_slow = ENC_W'(d8 >> 3) | (ENC_W'(frac_remap(d8[2:0])) << 14);
        unique case (s.kind)
            KIND_SLOW:
            begin
                r.dvs = DVS_W'(d8);
                r.enc = enc_slow;
            end
            KIND_FAST16:
            begin
                r.dvs = DVS_FAST16;
                r.enc = ENC_FAST16;
            end
            KIND_FAST24:
            begin
                r.dvs = DVS_FAST24;
                r.enc = ENC_FAST24;
            end
            KIND_FAST32:
            begin
                r.dvs = DVS_FAST32;
                r.enc = ENC_FAST32;
            end
            default:
            begin
                r.dvs = DVS_UNIT;
                r.enc = ENC_FAST16;
            end
        endcase
        if (s.rej)
        begin
            r.dvs = DVS_UNIT;
            r.enc = '0;
        end
        r.rem = '0;
        r.dq  = s.base;
        return r;
    endfunction

    function automatic out_t result_of(input pl_t s);
        out_t              o;
        logic [BASE_W-1:0] rnd;
        rnd = {1'b0, s.dq[BASE_W-1:1]} + BASE_W'(s.dq[0]);
        o.rejected = s.rej;
        o.achieved = (s.kind == KIND_SLOW) ? rnd[ACH_W-1:0] : s.dq[ACH_W-1:0];
        o.value    = s.enc[VAL_W-1:0];
        o.index    = s.enc[ENC_W-1];
        if (s.rej)
        begin
            o.achieved = '0;
            o.value    = '0;
            o.index    = 1'b0;
        end
        return o;
    endfunction

endpackage

`default_nettype wire

>>> rtl/uart_baud_divisor_encoder_core.sv
// ----------------------------------------------------------------------------
// uart_baud_divisor_encoder_core
// turns a requested baud rate into the encoded fractional divisor of a
// usb serial bridge (prescale 16) and the baud rate that divisor achieves
// ----------------------------------------------------------------------------
// Takes one request per clock while s_tready is high and returns one result
// per request, in order. Items pass through an input register, two 28-bit
// restoring dividers of 14 stages each (two quotient bits per stage), one
// stage that forms and encodes the eighths divisor, and the output register.
// On the slow path the first divider forms clock/baud, the second the
// achieved rate as clock/divisor. A skid register behind the output keeps
// the pipeline moving for one more item while a result waits; only when both
// are full does s_tready drop. Rates of zero or below come back with the
// tuser flag set and all data zero. The base clock is written over the cfg
// port (reset 48 MHz) and must only change while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_baud_divisor_encoder_core_assert.svh"

module uart_baud_divisor_encoder_core
    import ubde_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [BASE_W-1:0]    cfg_data,     // clock_hz
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BAUD_W-1:0]    s_tdata,      // requested_baud (signed)
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,      // achieved_baud, value_word, index_word
    output logic                      m_tuser       // rejected
);

    logic [BASE_W-1:0]     clock_hz_reg;
    logic [NUM_STAGES-1:0] v_reg;
    pl_t                   st_reg  [NUM_STAGES];
    pl_t                   st_next [NUM_STAGES];
    out_t                  out_reg, out_next, skid_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic                  load_out, load_skid, en, out_free;

    logic                  in_rej;
    logic [CMP_W-1:0]      b1, base_ext, m16, m24, m32;
    kind_t                 in_kind;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= CLOCK_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            clock_hz_reg <= cfg_data;
        end
    end

    // fast-rate tests: rate >= floor(clk/n) exactly when n*(rate+1) > clk
    assign in_rej   = (s_tdata == '0) || s_tdata[BAUD_W-1];
    assign b1       = CMP_W'(s_tdata[BAUD_W-2:0]) + CMP_W'(1);
    assign base_ext = CMP_W'(clock_hz_reg);
    assign m16      = b1 << 4;
    assign m24      = (b1 << 4) + (b1 << 3);
    assign m32      = b1 << 5;

    always_comb
    begin
        priority if (m16 > base_ext)
        begin
            in_kind = KIND_FAST16;
        end
        else if (m24 > base_ext)
        begin
            in_kind = KIND_FAST24;
        end
        else if (m32 > base_ext)
        begin
            in_kind = KIND_FAST32;
        end
        else
        begin
            in_kind = KIND_SLOW;
        end
    end

    always_comb
    begin
        st_next[0].rej  = in_rej;
        st_next[0].kind = in_kind;
        st_next[0].base = clock_hz_reg;
        // on the slow path the rate is below clk/32, so it fits the divisor
        st_next[0].dvs  = (in_kind == KIND_SLOW && !in_rej) ? s_tdata[DVS_W-1:0] : DVS_UNIT;
        st_next[0].rem  = '0;
        st_next[0].dq   = clock_hz_reg;
        st_next[0].enc  = '0;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (i == MID_IDX)
            begin
                st_next[i] = mid_stage(st_reg[i-1]);
            end
            else
            begin
                st_next[i] = div_step(st_reg[i-1]);
            end
        end
    end

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NUM_STAGES-2:0], s_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                st_reg[i] <= st_next[i];
            end
        end
    end

    // output register with a skid slot behind it
    assign res_next = result_of(st_reg[LAST_IDX]);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = res_next;
        load_out        = 1'b0;
        load_skid       = 1'b0;
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_next        = skid_reg;
                load_out        = 1'b1;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_free)
        begin
            load_out       = 1'b1;
            out_valid_next = v_reg[LAST_IDX];
        end
        else if (v_reg[LAST_IDX])
        begin
            load_skid       = 1'b1;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= out_next;
        end
        if (load_skid)
        begin
            skid_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.rejected;
    assign m_tdata  = {PAD_W'(0), out_reg.index, out_reg.value, out_reg.achieved};

    `UBDE_ASSERT(a_rejected_zero, m_tvalid && m_tuser |-> m_tdata == '0, "rejected item carries data")
    `UBDE_ASSERT_NEVER(a_skid_without_out, skid_valid_reg && !out_valid_reg, "skid full, output empty")
    `UBDE_ASSERT(a_stall_from_output, !s_tready |-> m_tvalid && $past(m_tvalid), "stall without a waiting result")
    `UBDE_ASSERT(a_divisor_clamped, v_reg[MID_IDX] |-> st_reg[MID_IDX].dvs <= DVS_W'(DIV_CLAMP_LIMIT), "divisor above clamp")

endmodule

`default_nettype wire
